/* rtl/dts_pkg.sv */
// Shared types, constants and state codes for the topological sort engine.
package dts_pkg;

  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefMaxEdges    = 256;

  typedef struct packed {
    logic       opcode;
    logic [5:0] edge_src;
    logic [5:0] edge_dst;
  } dts_in_t;

  typedef struct packed {
    logic [5:0] vertex;
    logic       last;
    logic       edge_error;
  } dts_out_t;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_SORT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_ROOT,
    ST_TOP,
    ST_EREAD,
    ST_HEAD,
    ST_EVAL,
    ST_EMIT,
    ST_WAIT,
    ST_WIPE
  } dts_state_t;

  typedef struct packed {
    logic clear_step;   // write empty marker at clear index, advance
    logic clear_start;  // reset clear index
    logic edge_load;    // capture input word
    logic edge_commit;  // append captured edge or flag error
    logic root_step;    // test root, push if unvisited, advance root
    logic top_read;     // read top of search stack
    logic edge_read;    // issue edge memory read for top cursor
    logic head_read;    // read list head of the edge target
    logic edge_eval;    // update cursor, maybe push child
    logic pop;          // pop top to finish stack
    logic emit_start;   // begin emission
    logic emit_step;    // hand one result word out
    logic wipe;         // clear visited, counters, error
  } dts_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic roots_done;
    logic root_free;
    logic stack_empty;
    logic stack_one;
    logic cursor_end;
    logic fin_empty;
    logic emit_last;
    logic is_sort;
  } dts_sts_t;

endpackage

/* rtl/dts_datapath.sv */
// Datapath: adjacency memories, search and finish stacks, emission register.
module dts_datapath #(
  parameter int unsigned MAX_VERTICES = dts_pkg::DefMaxVertices,
  parameter int unsigned MAX_EDGES    = dts_pkg::DefMaxEdges
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dts_pkg::dts_cmd_t cmd,
  output dts_pkg::dts_sts_t sts,
  input  dts_pkg::dts_in_t  in_word,
  input  logic [6:0]       vertex_count,
  output dts_pkg::dts_out_t out_word
);
  import dts_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned VC = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);   // link incl. none marker
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [EW-1:0] LinkNone = EW'(MAX_EDGES);
  localparam int unsigned LimV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

  logic [5:0]    tgt_mem  [MAX_EDGES];
  logic [EW-1:0] link_mem [MAX_EDGES];
  logic [EW-1:0] head_mem [MAX_VERTICES];
  logic [EW-1:0] tail_mem [MAX_VERTICES];
  logic [VW-1:0] svert_mem[MAX_VERTICES];
  logic [EW-1:0] scur_mem [MAX_VERTICES];
  logic [5:0]    fin_mem  [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] visited_r;
  logic [VC-1:0] clr_r, root_r, sp_r, fin_r, emit_r;
  logic [EW-1:0] stored_r;
  logic          err_r;
  logic [6:0]    n_w;

  dts_in_t       in_r;
  logic [VW-1:0] top_v_r;
  logic [EW-1:0] top_e_r;
  logic [5:0]    w_r;
  logic [EW-1:0] nxt_r;
  logic [EW-1:0] head_w_r;
  logic [EW-1:0] head_rd_r, tail_rd_r;
  logic [EW-1:0] root_head_r;
  dts_out_t      out_r;

  assign n_w = (vertex_count > 7'(LimV)) ? 7'(LimV) : vertex_count;

  logic src_ok, dst_ok, w_ok;
  assign src_ok = {1'b0, in_r.edge_src} < n_w;
  assign dst_ok = {1'b0, in_r.edge_dst} < n_w;
  assign w_ok   = ({1'b0, w_r} < n_w) && !visited_r[VW'(w_r)]
                  && (sp_r < VC'(MAX_VERTICES));

  // Memory ports
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      head_mem[clr_r[VW-1:0]] <= LinkNone;
      tail_mem[clr_r[VW-1:0]] <= LinkNone;
    end
    if (cmd.edge_load) begin
      head_rd_r <= head_mem[VW'(in_word.edge_src)];
      tail_rd_r <= tail_mem[VW'(in_word.edge_src)];
    end
    if (cmd.edge_commit && src_ok && dst_ok && stored_r < EW'(MAX_EDGES)) begin
      tgt_mem[stored_r[AW-1:0]]  <= in_r.edge_dst;
      link_mem[stored_r[AW-1:0]] <= LinkNone;
      if (head_rd_r == LinkNone) head_mem[VW'(in_r.edge_src)] <= stored_r;
      else link_mem[tail_rd_r[AW-1:0]] <= stored_r;
      tail_mem[VW'(in_r.edge_src)] <= stored_r;
    end
    if (cmd.root_step) root_head_r <= head_mem[root_r[VW-1:0]];
    if (cmd.top_read) begin
      top_v_r <= svert_mem[sp_r[VW-1:0] - VW'(1)];
      top_e_r <= scur_mem[sp_r[VW-1:0] - VW'(1)];
    end
    if (cmd.edge_read) begin
      w_r   <= tgt_mem[top_e_r[AW-1:0]];
      nxt_r <= link_mem[top_e_r[AW-1:0]];
    end
    if (cmd.head_read) head_w_r <= head_mem[VW'(w_r)];
    if (cmd.root_step && root_r < VC'(n_w) && !visited_r[root_r[VW-1:0]]) begin
      svert_mem[0] <= root_r[VW-1:0];
      scur_mem[0]  <= head_mem[root_r[VW-1:0]];
    end
    if (cmd.edge_eval) begin
      scur_mem[sp_r[VW-1:0] - VW'(1)] <= nxt_r;
      if (w_ok) begin
        svert_mem[sp_r[VW-1:0]] <= VW'(w_r);
        scur_mem[sp_r[VW-1:0]]  <= head_w_r;
      end
    end
    if (cmd.pop) fin_mem[fin_r[VW-1:0]] <= 6'(top_v_r);
    if (cmd.emit_step || cmd.emit_start) begin
      out_r.vertex     <= fin_mem[(cmd.emit_start ? fin_r[VW-1:0] : emit_r[VW-1:0]) - VW'(1)];
      out_r.last       <= cmd.emit_start ? (fin_r == VC'(1)) : (emit_r == VC'(1));
      out_r.edge_error <= err_r;
    end
  end

  // Control-carrying registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; root_r <= '0; sp_r <= '0; fin_r <= '0; emit_r <= '0;
      stored_r <= '0; err_r <= 1'b0; visited_r <= '0;
    end else begin
      if (cmd.clear_start) clr_r <= '0;
      else if (cmd.clear_step) clr_r <= clr_r + VC'(1);
      if (cmd.edge_load) in_r <= in_word;
      if (cmd.edge_commit) begin
        if (src_ok && dst_ok && stored_r < EW'(MAX_EDGES)) stored_r <= stored_r + EW'(1);
        else err_r <= 1'b1;
      end
      if (cmd.root_step) begin
        root_r <= root_r + VC'(1);
        if (root_r < VC'(n_w) && !visited_r[root_r[VW-1:0]]) begin
          visited_r[root_r[VW-1:0]] <= 1'b1;
          sp_r <= VC'(1);
        end
      end
      if (cmd.edge_eval && w_ok) begin
        visited_r[VW'(w_r)] <= 1'b1;
        sp_r <= sp_r + VC'(1);
      end
      if (cmd.pop) begin
        sp_r  <= sp_r - VC'(1);
        fin_r <= fin_r + VC'(1);
      end
      if (cmd.emit_start) emit_r <= fin_r - VC'(1);
      else if (cmd.emit_step) emit_r <= emit_r - VC'(1);
      if (cmd.wipe) begin
        visited_r <= '0; root_r <= '0; sp_r <= '0; fin_r <= '0;
        stored_r <= '0; err_r <= 1'b0;
      end
    end
  end

  assign sts.clear_done  = (clr_r == VC'(MAX_VERTICES - 1));
  assign sts.roots_done  = (root_r >= VC'(n_w));
  assign sts.root_free   = !visited_r[root_r[VW-1:0]];
  assign sts.stack_empty = (sp_r == '0);
  assign sts.stack_one   = (sp_r == VC'(1));
  assign sts.cursor_end  = (top_e_r >= EW'(MAX_EDGES));
  assign sts.fin_empty   = (fin_r == '0);
  assign sts.emit_last   = (emit_r == '0);
  assign sts.is_sort     = (in_word.opcode == OP_SORT);
  assign out_word        = out_r;

  // root_head_r mirrors the pushed root cursor; keep it consistent
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_step && !sts.roots_done && sts.root_free |=> scur_mem[0] == root_head_r)
    else $error("root cursor mismatch");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.stack_empty) else $error("pop on empty stack");
  assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= VC'(MAX_VERTICES)) else $error("search stack overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wipe |=> sts.fin_empty && sts.stack_empty) else $error("wipe incomplete");
endmodule

/* rtl/dts_ctrl.sv */
// Controller state machine sequencing edge load, search and emission.
module dts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dts_pkg::dts_sts_t sts,
  output dts_pkg::dts_cmd_t cmd
);
  import dts_pkg::*;

  dts_state_t state_r, state_nxt;
  logic       acc;

  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // ST_EREAD pops when cursor is exhausted; sp is still the pre-pop depth there
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (acc) state_nxt = sts.is_sort ? ST_ROOT : ST_EDGE;
      ST_EDGE:  state_nxt = ST_IDLE;
      ST_ROOT: begin
        if (sts.roots_done) state_nxt = sts.fin_empty ? ST_WIPE : ST_EMIT;
        else if (sts.root_free) state_nxt = ST_TOP;
      end
      ST_TOP:   state_nxt = ST_EREAD;
      ST_EREAD: state_nxt = sts.cursor_end ? (sts.stack_one ? ST_ROOT : ST_TOP)
                                           : ST_HEAD;
      ST_HEAD:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_TOP;
      ST_EMIT:  state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!out_stall) state_nxt = sts.emit_last ? ST_WIPE : ST_WAIT;
      end
      ST_WIPE:  state_nxt = ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.edge_load = in_valid;
      end
      ST_EDGE:  cmd.edge_commit = 1'b1;
      ST_ROOT: begin
        cmd.root_step  = !sts.roots_done;
        cmd.emit_start = sts.roots_done && !sts.fin_empty;
      end
      ST_TOP:   cmd.top_read = 1'b1;
      ST_EREAD: begin
        cmd.pop       = sts.cursor_end;
        cmd.edge_read = !sts.cursor_end;
      end
      ST_HEAD:  cmd.head_read = 1'b1;
      ST_EVAL:  cmd.edge_eval = 1'b1;
      ST_EMIT:  out_valid = 1'b0;
      ST_WAIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = !out_stall && !sts.emit_last;
      end
      ST_WIPE: begin
        cmd.wipe        = 1'b1;
        cmd.clear_start = 1'b1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during emission");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !cmd.edge_read) else $error("pop and read together");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WIPE |=> state_r == ST_CLEAR) else $error("wipe not followed by clear");
endmodule

/* rtl/dfs_topological_sort.sv */
// Top level of the depth-first topological sort engine.
// Edge words pass through ST_IDLE and ST_EDGE. A sort word runs a depth-first search over n
// vertices and E walked edges (each edge step reads the edge, then the target's list head),
// then a setup state and one result word per cycle while out_stall is low, then a wipe
// and a pass that resets all MAX_VERTICES list heads; the same pass runs after
// reset. The input is stalled from a sort word until that pass ends.
module dfs_topological_sort #(
  parameter int unsigned MAX_VERTICES = dts_pkg::DefMaxVertices,
  parameter int unsigned MAX_EDGES    = dts_pkg::DefMaxEdges
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dts_pkg::dts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dts_pkg::dts_out_t out_data,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);
  import dts_pkg::*;

  dts_cmd_t   cmd;
  dts_sts_t   sts;
  logic [6:0] vertex_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vertex_count_r <= 7'd64;
    else if (cfg_we) vertex_count_r <= cfg_wdata;
  end

  dts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  dts_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_word(in_data), .vertex_count(vertex_count_r),
    .out_word(out_data)
  );
endmodule
